// ===== rtl/core/lzss4k_pkg.sv =====
package lzss4k_pkg;

	localparam int WinSize = 4096;
	localparam int WinAw   = $clog2(WinSize);
	localparam int FillW   = WinAw + 1;

	localparam logic [WinAw-1:0] WriteStart = WinAw'(12'hFEE);
	localparam logic [4:0]       LenBias    = 5'd3;
	localparam logic [3:0]       FlagTokens = 4'd8;

	typedef logic [WinAw-1:0] win_addr_t;
	typedef logic [FillW-1:0] fill_cnt_t;

endpackage

// ===== rtl/core/lzss_4k_window_decompressor.sv =====
// LZSS decompressor, 4096-byte history window.
// Input channel: comp_byte/in_last with in_valid/in_stall, one compressed byte
// per request. Output channel: out_byte/run_last with out_valid/out_stall, one
// decompressed byte per request; run_last marks the final byte caused by an
// input request. End of stream is not marked on the output side.
// Steps: a flag byte or a reference low byte is taken and gives no output.
// A literal is written to the window and shows on the output the next cycle.
// A reference high byte starts a copy of 3..18 bytes, each read from the window
// RAM, then written back and output; no new request is taken until it ends.
// The window RAM, one port per direction with registered read, sets these steps.
// Reset: the window reads as zero until written, tracked by a fill count, so
// no clearing pass is needed; the write position restarts at 0xFEE. An input
// marked in_last restores this state once its output bytes are written.
// Stall: while out_stall holds a result, the copy sequencer waits and in_stall
// stays high; nothing is dropped.
module lzss_4k_window_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] comp_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import lzss4k_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR} state_t;

	state_t    state_q;
	win_addr_t wp_q;
	fill_cnt_t fill_q;
	logic [7:0] flags_q;
	logic [3:0] tok_q;
	logic [7:0] low_q;
	logic       await_q;
	win_addr_t src_q;
	logic [4:0] left_q;
	logic       last_q;
	logic       hit_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	logic       in_acc;
	logic       out_free;
	logic       lit_go;
	logic       wr_go;
	logic       ram_we;
	logic       ram_re;
	logic [7:0] ram_wdata;
	logic [7:0] ram_rdata;
	logic       hit;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign lit_go    = in_acc && !await_q && (tok_q != 4'd0) && flags_q[0];
	assign wr_go     = (state_q == ST_WR) && out_free;
	assign ram_we    = lit_go || wr_go;
	assign ram_re    = (state_q == ST_RD);
	assign ram_wdata = lit_go ? comp_byte : (hit_q ? ram_rdata : 8'd0);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	lzss4k_ram #(
		.Width(8),
		.Depth(WinSize)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(src_q),
		.rdata(ram_rdata)
	);

	lzss4k_vchk u_vchk (
		.addr(src_q),
		.fill(fill_q),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= WriteStart;
			fill_q      <= '0;
			flags_q     <= '0;
			tok_q       <= '0;
			low_q       <= '0;
			await_q     <= 1'b0;
			src_q       <= '0;
			left_q      <= '0;
			last_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			run_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= ram_wdata;
				run_last_q  <= lit_go || (left_q == 5'd1);
				wp_q        <= wp_q + 1'b1;
				if (fill_q != FillW'(WinSize)) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (await_q) begin
							src_q   <= {comp_byte[7:4], low_q};
							left_q  <= {1'b0, comp_byte[3:0]} + LenBias;
							last_q  <= in_last;
							await_q <= 1'b0;
							state_q <= ST_RD;
						end else if (tok_q == 4'd0) begin
							flags_q <= comp_byte;
							tok_q   <= FlagTokens;
						end else begin
							flags_q <= {1'b0, flags_q[7:1]};
							tok_q   <= tok_q - 1'b1;
							if (!flags_q[0]) begin
								low_q   <= comp_byte;
								await_q <= 1'b1;
							end
						end
						// end of stream on a byte that starts no copy: back to the start state
						if (in_last && !await_q) begin
							wp_q    <= WriteStart;
							fill_q  <= '0;
							flags_q <= '0;
							tok_q   <= '0;
							low_q   <= '0;
							await_q <= 1'b0;
						end
					end
				end
				ST_RD: begin
					hit_q   <= hit;
					src_q   <= src_q + 1'b1;
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (out_free) begin
						left_q <= left_q - 1'b1;
						if (left_q == 5'd1) begin
							state_q <= ST_IDLE;
							if (last_q) begin
								wp_q    <= WriteStart;
								fill_q  <= '0;
								flags_q <= '0;
								tok_q   <= '0;
								low_q   <= '0;
								await_q <= 1'b0;
								last_q  <= 1'b0;
							end
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(WinSize))
		else $error("fill count beyond window size");

	a_copy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (left_q != 5'd0))
		else $error("copy running with no bytes left");

	a_wr_lands_out: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (out_valid_q && out_byte_q == $past(ram_wdata)))
		else $error("window write not mirrored on output");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_last && !await_q) |=> (wp_q == WriteStart && fill_q == '0))
		else $error("state not restored after last byte");

	a_copy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && await_q) |=> (state_q == ST_RD && in_stall))
		else $error("reference did not start a copy");

endmodule

// ===== rtl/core/lzss4k_ram.sv =====
module lzss4k_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/lzss4k_vchk.sv =====
module lzss4k_vchk (
	input  lzss4k_pkg::win_addr_t addr,
	input  lzss4k_pkg::fill_cnt_t fill,
	output logic                  hit
);
	import lzss4k_pkg::*;

	win_addr_t offset;

	// writes run sequentially from the start position, so an entry holds data
	// iff its distance from the start is below the number of bytes written
	assign offset = addr - WriteStart;
	assign hit    = {1'b0, offset} < fill;

endmodule
